/* hdl/gdp_pkg.sv */
// ----------------------------------------------------------------------------
// gdp_pkg
// Shared types and constants for the GTP-U decapsulation payload parser:
// parse stages, status codes, header sizes and the structs between modules.
// ----------------------------------------------------------------------------
package gdp_pkg;

    // Parse stages, one per header being walked
    typedef enum logic [3:0] {
        ST_LINK     = 4'd0,
        ST_OUT_IP   = 4'd1,
        ST_OUT_UDP  = 4'd2,
        ST_GTP_BASE = 4'd3,
        ST_GTP_NEXT = 4'd4,
        ST_GTP_LEN  = 4'd5,
        ST_GTP_SKIP = 4'd6,
        ST_IN_IP    = 4'd7,
        ST_TRANS    = 4'd8,
        ST_PAYLOAD  = 4'd9
    } gdp_stage_t;

    // Packet status reported with the last byte
    typedef enum logic [3:0] {
        STATUS_OK            = 4'd0,
        STATUS_EMPTY         = 4'd1,
        STATUS_BAD_LINK      = 4'd2,
        STATUS_BAD_OUTER_IP  = 4'd3,
        STATUS_OUTER_NOT_UDP = 4'd4,
        STATUS_SHORT_UDP     = 4'd5,
        STATUS_BAD_GTP       = 4'd6,
        STATUS_BAD_INNER_IP  = 4'd7,
        STATUS_UNSUPPORTED   = 4'd8,
        STATUS_BAD_TRANSPORT = 4'd9,
        STATUS_PROTO_MISMATCH = 4'd10
    } gdp_status_t;

    // Configuration register map (register index = paddr[3:2])
    localparam int          APB_ADDR_W      = 4;
    localparam int          APB_DATA_W      = 32;
    localparam logic [1:0]  REG_TUNNEL_MODE = 2'd0;
    localparam logic [1:0]  REG_LINK_TYPE   = 2'd1;
    localparam logic [1:0]  REG_INNER_PROTO = 2'd2;

    // Register reset values
    localparam logic        TUNNEL_MODE_RST = 1'b1;
    localparam logic [1:0]  LINK_TYPE_RST   = 2'd0;
    localparam logic [7:0]  INNER_PROTO_RST = 8'd17;

    // Link types
    localparam logic [1:0]  LINK_ETHERNET   = 2'd0;
    localparam logic [1:0]  LINK_RAW_IP     = 2'd1;

    // Header geometry
    localparam logic [7:0]  ETH_HDR_LEN     = 8'd14;
    localparam logic [7:0]  UDP_HDR_LEN     = 8'd8;
    localparam logic [7:0]  GTP_HDR_LEN     = 8'd8;
    localparam logic [7:0]  TCP_HDR_LEN     = 8'd20;
    localparam logic [3:0]  IP_MIN_IHL      = 4'd5;
    localparam logic [3:0]  TCP_MIN_DOFF    = 4'd5;
    localparam logic [7:0]  IP_PROTO_OFFSET = 8'd9;
    localparam logic [7:0]  TCP_DOFF_OFFSET = 8'd12;
    localparam int          GTP_E_FLAG_BIT  = 2;

    // Protocol numbers
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;

    // Hash: djb2 reduced to its bucket bits (the modulus is a power of two)
    localparam int          HASH_BUCKETS    = 1024;
    localparam int          BUCKET_BITS     = $clog2(HASH_BUCKETS);
    localparam logic [31:0] HASH_SEED       = 32'd5381;
    localparam logic [BUCKET_BITS-1:0] HASH_INIT = HASH_SEED[BUCKET_BITS-1:0];

    // Result field widths
    localparam int          STATUS_W        = 4;
    localparam int          LENGTH_W        = 16;

    typedef struct packed {
        logic       tunnel_mode;
        logic [1:0] link_type;
        logic [7:0] inner_protocol;
    } gdp_cfg_t;

    // Header walker verdict for the byte in process
    typedef struct packed {
        logic        payload_en;
        logic        hdr_ok;
        gdp_status_t hdr_status;
    } gdp_parse_t;

    // Per-packet summary, nonzero only on the last byte
    typedef struct packed {
        gdp_status_t             status;
        logic [LENGTH_W-1:0]     payload_length;
        logic [BUCKET_BITS-1:0]  hash_bucket;
    } gdp_summary_t;

    typedef struct packed {
        logic [7:0]   payload_byte;
        logic         payload_valid;
        logic         packet_done;
        gdp_summary_t summary;
    } gdp_result_t;

endpackage

/* hdl/gdp_if.sv */
// ----------------------------------------------------------------------------
// gdp_if
// Valid/ready channel interfaces: packet bytes in, per-byte results out.
// ----------------------------------------------------------------------------
interface gdp_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface gdp_res_if;
    logic                            valid;
    logic                            ready;
    logic [7:0]                      payload_byte;
    logic                            payload_valid;
    logic                            packet_done;
    logic [gdp_pkg::STATUS_W-1:0]    status;
    logic [gdp_pkg::LENGTH_W-1:0]    payload_length;
    logic [gdp_pkg::BUCKET_BITS-1:0] hash_bucket;

    modport source (output valid, output payload_byte, output payload_valid,
                    output packet_done, output status, output payload_length,
                    output hash_bucket, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input packet_done, input status, input payload_length,
                    input hash_bucket, output ready);
endinterface

/* hdl/gtpu_decap_payload_parser.sv */
// ----------------------------------------------------------------------------
// gtpu_decap_payload_parser
// GTP-U / plain IP header parser that flags payload bytes and reports
// status, payload length and a djb2 hash bucket per packet.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle unless stalled as below, and gives one
// result per byte in the same order. Each accepted byte sits in an input
// register, is processed by the header walker and payload accumulator in a
// single step, and lands in the result register; the step that updates the
// per-packet parse state sets the one-cycle rate. A new byte is taken while a
// finished result waits, stalling only when both registers are full and the
// result is not taken. APB configuration writes go in while the block is idle,
// a user rule the block does not enforce; no clearing pass follows reset.
module gtpu_decap_payload_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    gdp_pkt_if.sink                        pkt_in,
    gdp_res_if.source                      res_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gdp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gdp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gdp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    gdp_pkg::gdp_cfg_t     cfg;
    gdp_pkg::gdp_parse_t   parse;
    gdp_pkg::gdp_summary_t summary;
    gdp_pkg::gdp_result_t  out_data_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       step;

    // Advance when an item waits and the result register is free or drains
    assign step         = in_valid_reg && (!out_valid_reg || res_out.ready);
    assign pkt_in.ready = !in_valid_reg || step;

    gdp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gdp_parse_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .cfg     (cfg),
        .parse   (parse)
    );

    gdp_payload_acc #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .parse   (parse),
        .summary (summary)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pkt_in.ready)
        begin
            in_valid_reg <= pkt_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_in.ready && pkt_in.valid)
        begin
            in_byte_reg <= pkt_in.packet_byte;
            in_last_reg <= pkt_in.last_byte;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg.payload_byte  <= in_byte_reg;
            out_data_reg.payload_valid <= parse.payload_en;
            out_data_reg.packet_done   <= in_last_reg;
            out_data_reg.summary       <= summary;
        end
    end

    assign res_out.valid          = out_valid_reg;
    assign res_out.payload_byte   = out_data_reg.payload_byte;
    assign res_out.payload_valid  = out_data_reg.payload_valid;
    assign res_out.packet_done    = out_data_reg.packet_done;
    assign res_out.status         = out_data_reg.summary.status;
    assign res_out.payload_length = out_data_reg.summary.payload_length;
    assign res_out.hash_bucket    = out_data_reg.summary.hash_bucket;

    // A good packet always carries a nonzero payload length
    a_ok_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.packet_done && res_out.status == gdp_pkg::STATUS_OK
        |-> res_out.payload_length != '0)
        else $error("ok status with zero payload length");

    // Mid-packet results carry no summary
    a_mid_packet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.packet_done
        |-> res_out.status == gdp_pkg::STATUS_OK && res_out.payload_length == '0 &&
            res_out.hash_bucket == '0)
        else $error("summary fields set before the last byte");

    // A failed packet reports no length and no bucket
    a_error_no_summary: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.status != gdp_pkg::STATUS_OK
        |-> res_out.payload_length == '0 && res_out.hash_bucket == '0)
        else $error("length or bucket reported with an error status");

    // A held input item stays put while the result register is blocked
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !res_out.ready
        |=> in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg))
        else $error("input item lost while output stalled");

endmodule

/* hdl/gdp_apb_regs.sv */
// ----------------------------------------------------------------------------
// gdp_apb_regs
// APB configuration registers: tunnel mode, link type, inner protocol.
// ----------------------------------------------------------------------------
module gdp_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gdp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gdp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gdp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output gdp_pkg::gdp_cfg_t                cfg
);

    logic       tunnel_mode_reg;
    logic [1:0] link_type_reg;
    logic [7:0] inner_proto_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Write selected register on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tunnel_mode_reg <= gdp_pkg::TUNNEL_MODE_RST;
            link_type_reg   <= gdp_pkg::LINK_TYPE_RST;
            inner_proto_reg <= gdp_pkg::INNER_PROTO_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                gdp_pkg::REG_TUNNEL_MODE: tunnel_mode_reg <= pwdata[0];
                gdp_pkg::REG_LINK_TYPE:   link_type_reg   <= pwdata[1:0];
                gdp_pkg::REG_INNER_PROTO: inner_proto_reg <= pwdata[7:0];
                default:                  ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_index)
            gdp_pkg::REG_TUNNEL_MODE: prdata = {31'd0, tunnel_mode_reg};
            gdp_pkg::REG_LINK_TYPE:   prdata = {30'd0, link_type_reg};
            gdp_pkg::REG_INNER_PROTO: prdata = {24'd0, inner_proto_reg};
            default:                  prdata = '0;
        endcase
    end

    assign cfg.tunnel_mode    = tunnel_mode_reg;
    assign cfg.link_type      = link_type_reg;
    assign cfg.inner_protocol = inner_proto_reg;

endmodule

/* hdl/gdp_parse_fsm.sv */
// ----------------------------------------------------------------------------
// gdp_parse_fsm
// Header walker: tracks the current header and byte offset, checks IHL,
// protocol, GTP extension chain and TCP data offset, one byte per step.
// ----------------------------------------------------------------------------
module gdp_parse_fsm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          byte_in,
    input  logic                last_in,
    input  gdp_pkg::gdp_cfg_t   cfg,
    output gdp_pkg::gdp_parse_t parse
);

    gdp_pkg::gdp_stage_t  stage_reg, stage_next, work_stage;
    gdp_pkg::gdp_status_t err_reg, err_next;
    logic [7:0] bih_reg, bih_next, work_bih, bih_plus;
    logic [7:0] hl_reg, hl_next, ip_hl, trans_hl, trans_len;
    logic [7:0] ext_reg, ext_next, ext_dec;
    logic       flag_reg, flag_next;
    logic [7:0] proto_reg, proto_next;
    logic [3:0] ihl, doff;
    logic       ip_first, ip_bad, ip_done, inner_ok, tcp_chk;

    function automatic gdp_pkg::gdp_status_t trunc_code(gdp_pkg::gdp_stage_t s);
        gdp_pkg::gdp_status_t code;
        unique case (s)
            gdp_pkg::ST_LINK:    code = gdp_pkg::STATUS_BAD_LINK;
            gdp_pkg::ST_OUT_IP:  code = gdp_pkg::STATUS_BAD_OUTER_IP;
            gdp_pkg::ST_OUT_UDP: code = gdp_pkg::STATUS_SHORT_UDP;
            gdp_pkg::ST_IN_IP:   code = gdp_pkg::STATUS_BAD_INNER_IP;
            gdp_pkg::ST_TRANS:   code = gdp_pkg::STATUS_BAD_TRANSPORT;
            default:             code = gdp_pkg::STATUS_BAD_GTP;
        endcase
        return code;
    endfunction

    // Raw IP link enters the IP header on its first byte
    assign work_stage = (stage_reg == gdp_pkg::ST_LINK) ? gdp_pkg::ST_OUT_IP : stage_reg;
    assign work_bih   = (stage_reg == gdp_pkg::ST_LINK) ? 8'd0 : bih_reg;
    assign bih_plus   = work_bih + 8'd1;

    // IPv4 header length and completion
    assign ihl      = byte_in[3:0];
    assign ip_first = (work_bih == 8'd0);
    assign ip_bad   = ip_first && (ihl < gdp_pkg::IP_MIN_IHL);
    assign ip_hl    = ip_first ? {2'b00, ihl, 2'b00} : hl_reg;
    assign ip_done  = (bih_plus >= ip_hl);

    // Transport header length
    assign inner_ok  = (cfg.inner_protocol == gdp_pkg::PROTO_TCP) ||
                       (cfg.inner_protocol == gdp_pkg::PROTO_UDP);
    assign trans_len = (cfg.inner_protocol == gdp_pkg::PROTO_TCP) ?
                       gdp_pkg::TCP_HDR_LEN : gdp_pkg::UDP_HDR_LEN;
    assign doff      = byte_in[7:4];
    assign tcp_chk   = (work_bih == gdp_pkg::TCP_DOFF_OFFSET) &&
                       (cfg.inner_protocol == gdp_pkg::PROTO_TCP);
    assign trans_hl  = tcp_chk ? {2'b00, doff, 2'b00} : hl_reg;
    assign ext_dec   = ext_reg - 8'd1;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= gdp_pkg::ST_LINK;
            err_reg   <= gdp_pkg::STATUS_OK;
            bih_reg   <= '0;
            hl_reg    <= '0;
            ext_reg   <= '0;
            flag_reg  <= 1'b0;
            proto_reg <= '0;
        end
        else if (step)
        begin
            stage_reg <= stage_next;
            err_reg   <= err_next;
            bih_reg   <= bih_next;
            hl_reg    <= hl_next;
            ext_reg   <= ext_next;
            flag_reg  <= flag_next;
            proto_reg <= proto_next;
        end
    end

    // Next state and verdict
    always_comb
    begin
        stage_next       = stage_reg;
        err_next         = err_reg;
        bih_next         = bih_reg;
        hl_next          = hl_reg;
        ext_next         = ext_reg;
        flag_next        = flag_reg;
        proto_next       = proto_reg;
        parse.payload_en = 1'b0;

        if (err_reg == gdp_pkg::STATUS_OK)
        begin
            if (stage_reg == gdp_pkg::ST_PAYLOAD)
            begin
                parse.payload_en = 1'b1;
            end
            else if (stage_reg == gdp_pkg::ST_LINK &&
                     cfg.link_type != gdp_pkg::LINK_ETHERNET &&
                     cfg.link_type != gdp_pkg::LINK_RAW_IP)
            begin
                err_next = gdp_pkg::STATUS_BAD_LINK;
            end
            else if (stage_reg == gdp_pkg::ST_LINK &&
                     cfg.link_type == gdp_pkg::LINK_ETHERNET)
            begin
                // Skip the Ethernet header
                bih_next = bih_reg + 8'd1;
                if (bih_next >= gdp_pkg::ETH_HDR_LEN)
                begin
                    stage_next = gdp_pkg::ST_OUT_IP;
                    bih_next   = '0;
                end
            end
            else
            begin
                stage_next = work_stage;
                bih_next   = work_bih;
                unique case (work_stage)
                    gdp_pkg::ST_OUT_IP, gdp_pkg::ST_IN_IP:
                    begin
                        if (ip_bad)
                        begin
                            err_next = (work_stage == gdp_pkg::ST_OUT_IP) ?
                                       gdp_pkg::STATUS_BAD_OUTER_IP :
                                       gdp_pkg::STATUS_BAD_INNER_IP;
                        end
                        else
                        begin
                            hl_next  = ip_hl;
                            bih_next = bih_plus;
                            if (work_bih == gdp_pkg::IP_PROTO_OFFSET)
                            begin
                                proto_next = byte_in;
                            end
                            if (ip_done)
                            begin
                                if (work_stage == gdp_pkg::ST_OUT_IP && cfg.tunnel_mode)
                                begin
                                    if (proto_reg != gdp_pkg::PROTO_UDP)
                                    begin
                                        err_next = gdp_pkg::STATUS_OUTER_NOT_UDP;
                                    end
                                    else
                                    begin
                                        stage_next = gdp_pkg::ST_OUT_UDP;
                                        bih_next   = '0;
                                    end
                                end
                                else if (work_stage == gdp_pkg::ST_OUT_IP &&
                                         proto_reg != cfg.inner_protocol)
                                begin
                                    err_next = gdp_pkg::STATUS_PROTO_MISMATCH;
                                end
                                else if (!inner_ok)
                                begin
                                    err_next = gdp_pkg::STATUS_UNSUPPORTED;
                                end
                                else
                                begin
                                    stage_next = gdp_pkg::ST_TRANS;
                                    bih_next   = '0;
                                    hl_next    = trans_len;
                                end
                            end
                        end
                    end
                    gdp_pkg::ST_OUT_UDP:
                    begin
                        bih_next = bih_plus;
                        if (bih_plus >= gdp_pkg::UDP_HDR_LEN)
                        begin
                            stage_next = gdp_pkg::ST_GTP_BASE;
                            bih_next   = '0;
                        end
                    end
                    gdp_pkg::ST_GTP_BASE:
                    begin
                        if (work_bih == 8'd0)
                        begin
                            flag_next = byte_in[gdp_pkg::GTP_E_FLAG_BIT];
                        end
                        bih_next = bih_plus;
                        if (bih_plus >= gdp_pkg::GTP_HDR_LEN)
                        begin
                            stage_next = flag_reg ? gdp_pkg::ST_GTP_NEXT : gdp_pkg::ST_IN_IP;
                            bih_next   = '0;
                        end
                    end
                    gdp_pkg::ST_GTP_NEXT:
                    begin
                        stage_next = (byte_in == 8'd0) ? gdp_pkg::ST_IN_IP : gdp_pkg::ST_GTP_LEN;
                        bih_next   = '0;
                    end
                    gdp_pkg::ST_GTP_LEN:
                    begin
                        ext_next   = byte_in;
                        stage_next = (byte_in == 8'd0) ? gdp_pkg::ST_GTP_NEXT :
                                                         gdp_pkg::ST_GTP_SKIP;
                        bih_next   = '0;
                    end
                    gdp_pkg::ST_GTP_SKIP:
                    begin
                        ext_next = ext_dec;
                        if (ext_dec == 8'd0)
                        begin
                            stage_next = gdp_pkg::ST_GTP_NEXT;
                            bih_next   = '0;
                        end
                    end
                    gdp_pkg::ST_TRANS:
                    begin
                        if (tcp_chk && doff < gdp_pkg::TCP_MIN_DOFF)
                        begin
                            err_next = gdp_pkg::STATUS_BAD_TRANSPORT;
                        end
                        else
                        begin
                            hl_next  = trans_hl;
                            bih_next = bih_plus;
                            if (bih_plus >= trans_hl)
                            begin
                                stage_next = gdp_pkg::ST_PAYLOAD;
                                bih_next   = '0;
                            end
                        end
                    end
                    default:
                    begin
                        stage_next = stage_reg;
                    end
                endcase
            end
        end

        // Verdict from the updated state
        parse.hdr_ok     = (err_next == gdp_pkg::STATUS_OK) &&
                           (stage_next == gdp_pkg::ST_PAYLOAD);
        parse.hdr_status = (err_next != gdp_pkg::STATUS_OK) ? err_next :
                           trunc_code(stage_next);

        // Drop all packet state after the last byte
        if (last_in)
        begin
            stage_next = gdp_pkg::ST_LINK;
            err_next   = gdp_pkg::STATUS_OK;
            bih_next   = '0;
            hl_next    = '0;
            ext_next   = '0;
            flag_next  = 1'b0;
            proto_next = '0;
        end
    end

endmodule

/* hdl/gdp_payload_acc.sv */
// ----------------------------------------------------------------------------
// gdp_payload_acc
// Payload byte counter (saturating) and djb2 hash kept at bucket width;
// forms the per-packet summary on the last byte.
// ----------------------------------------------------------------------------
module gdp_payload_acc #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            byte_in,
    input  logic                  last_in,
    input  gdp_pkg::gdp_parse_t   parse,
    output gdp_pkg::gdp_summary_t summary
);

    logic [LENGTH_BITS-1:0]          count_reg, count_upd;
    logic [gdp_pkg::BUCKET_BITS-1:0] hash_reg, hash_upd;

    // Count and hash payload bytes
    always_comb
    begin
        count_upd = count_reg;
        hash_upd  = hash_reg;
        if (parse.payload_en)
        begin
            if (count_reg != '1)
            begin
                count_upd = count_reg + LENGTH_BITS'(1);
            end
            hash_upd = hash_reg + (hash_reg << 5) + gdp_pkg::BUCKET_BITS'(byte_in);
        end
    end

    // Hold accumulators, clear after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hash_reg  <= gdp_pkg::HASH_INIT;
        end
        else if (step)
        begin
            count_reg <= last_in ? '0 : count_upd;
            hash_reg  <= last_in ? gdp_pkg::HASH_INIT : hash_upd;
        end
    end

    // Summary fields, zero except on the last byte; length and bucket only on a good one
    always_comb
    begin
        summary.status         = gdp_pkg::STATUS_OK;
        summary.payload_length = '0;
        summary.hash_bucket    = '0;
        if (last_in)
        begin
            if (!parse.hdr_ok)
            begin
                summary.status = parse.hdr_status;
            end
            else if (count_upd == '0)
            begin
                summary.status = gdp_pkg::STATUS_EMPTY;
            end
            else
            begin
                summary.payload_length = gdp_pkg::LENGTH_W'(count_upd);
                summary.hash_bucket    = hash_upd;
            end
        end
    end

endmodule

/* tb/sv/gtpu_decap_payload_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtpu_decap_payload_parser_tb
// Byte-stream test of the header parser. A few hand-picked bytes with known
// status run first. Random frames follow, mostly well-formed, some cut short,
// some with a corrupted byte and some pure noise. They run over a series of
// register settings, and the last one carries one payload long enough to
// saturate the length counter. Result items are checked against an in-bench
// header walker or the typed probe rows, with random idle gaps in most phases.
// ----------------------------------------------------------------------------
module gtpu_decap_payload_parser_tb;
    import gdp_pkg::*;

    localparam int          NUM_SETTINGS     = 9;
    localparam int          PHASE_BYTES      = 180;
    localparam int          LONG_PAYLOAD     = 65540;
    localparam int          DRAIN_CYCLES     = 20;
    localparam int          LIMIT_NS         = 20_000_000;
    localparam int          MAX_REPORTS      = 10;
    localparam logic [1:0]  LINK_UNSUPPORTED = 2'd3;

    typedef struct {
        logic [7:0]  b;
        logic        last;
        bit          typed;
        gdp_status_t st;
    } probe_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    gdp_pkt_if pkt_ch ();
    gdp_res_if res_ch ();

    gtpu_decap_payload_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt_in  (pkt_ch),
        .res_out (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register settings walked in order; the eighth is drawn at random
    gdp_cfg_t settings [NUM_SETTINGS] = '{
        '{1'b1, LINK_ETHERNET,    PROTO_UDP},
        '{1'b0, LINK_RAW_IP,      PROTO_TCP},
        '{1'b1, LINK_RAW_IP,      PROTO_TCP},
        '{1'b0, LINK_ETHERNET,    PROTO_UDP},
        '{1'b1, LINK_RAW_IP,      8'd255},
        '{1'b0, LINK_UNSUPPORTED, 8'd0},
        '{1'b0, LINK_RAW_IP,      8'd0},
        '{1'b1, LINK_ETHERNET,    PROTO_UDP},
        '{1'b0, LINK_RAW_IP,      PROTO_UDP}
    };

    // Hand-picked bytes under the reset settings
    probe_row_t probe_rows [18] = '{
        '{8'h00, 1'b1, 1'b1, STATUS_BAD_LINK},
        '{8'hFF, 1'b1, 1'b1, STATUS_BAD_LINK},
        '{8'hFF, 1'b0, 1'b0, STATUS_OK},
        '{8'h00, 1'b0, 1'b0, STATUS_OK},
        '{8'hAA, 1'b0, 1'b0, STATUS_OK},
        '{8'h55, 1'b0, 1'b0, STATUS_OK},
        '{8'h01, 1'b0, 1'b0, STATUS_OK},
        '{8'h80, 1'b0, 1'b0, STATUS_OK},
        '{8'hFE, 1'b0, 1'b0, STATUS_OK},
        '{8'h7F, 1'b0, 1'b0, STATUS_OK},
        '{8'h08, 1'b0, 1'b0, STATUS_OK},
        '{8'h00, 1'b0, 1'b0, STATUS_OK},
        '{8'h45, 1'b0, 1'b0, STATUS_OK},
        '{8'h00, 1'b0, 1'b0, STATUS_OK},
        '{8'h12, 1'b0, 1'b0, STATUS_OK},
        '{8'h34, 1'b0, 1'b0, STATUS_OK},
        '{8'h44, 1'b1, 1'b1, STATUS_BAD_OUTER_IP},
        '{8'hF0, 1'b1, 1'b1, STATUS_BAD_LINK}
    };

    // Register copies used by the header walker
    logic        cfg_tunnel;
    logic [1:0]  cfg_link;
    logic [7:0]  cfg_proto;

    // Header walker state
    gdp_stage_t  pr_stage;
    logic [7:0]  pr_pos;
    logic [7:0]  pr_len;
    logic [7:0]  pr_ext_left;
    logic [7:0]  pr_proto;
    logic        pr_ext_flag;
    gdp_status_t pr_fault;
    logic [15:0] pr_count;
    logic [31:0] pr_hash;

    gdp_result_t awaited_results [$];
    logic [7:0]  frame_q [$];

    int mismatches;
    int bytes_sent;
    int src_idle_pct;
    int snk_idle_pct;
    int status_tally [16];

    // ------------------------------------------------------------------
    // Header walker
    // ------------------------------------------------------------------
    function automatic void clear_walk();
        pr_stage    = ST_LINK;
        pr_pos      = '0;
        pr_len      = '0;
        pr_ext_left = '0;
        pr_ext_flag = 1'b0;
        pr_proto    = '0;
        pr_fault    = STATUS_OK;
        pr_count    = '0;
        pr_hash     = HASH_SEED;
    endfunction

    function automatic void move_to(gdp_stage_t s);
        pr_stage = s;
        pr_pos   = '0;
    endfunction

    function automatic void start_transport();
        move_to(ST_TRANS);
        pr_len = (cfg_proto == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN;
    endfunction

    // Take one IPv4 header byte; true once the header, options included, is in
    function automatic bit ip_header_done(logic [7:0] b, gdp_status_t code);
        if (pr_pos == 0)
        begin
            if (b[3:0] < IP_MIN_IHL)
            begin
                pr_fault = code;
                return 1'b0;
            end
            pr_len = {2'b00, b[3:0], 2'b00};
        end
        if (pr_pos == IP_PROTO_OFFSET)
            pr_proto = b;
        pr_pos++;
        return pr_pos >= pr_len;
    endfunction

    function automatic void walk_byte(logic [7:0] b);
        case (pr_stage)
            ST_OUT_IP:
                if (ip_header_done(b, STATUS_BAD_OUTER_IP))
                begin
                    if (cfg_tunnel)
                    begin
                        if (pr_proto != PROTO_UDP)
                            pr_fault = STATUS_OUTER_NOT_UDP;
                        else
                            move_to(ST_OUT_UDP);
                    end
                    else if (pr_proto != cfg_proto)
                        pr_fault = STATUS_PROTO_MISMATCH;
                    else if (cfg_proto != PROTO_TCP && cfg_proto != PROTO_UDP)
                        pr_fault = STATUS_UNSUPPORTED;
                    else
                        start_transport();
                end
            ST_OUT_UDP:
            begin
                pr_pos++;
                if (pr_pos >= UDP_HDR_LEN)
                    move_to(ST_GTP_BASE);
            end
            ST_GTP_BASE:
            begin
                if (pr_pos == 0)
                    pr_ext_flag = b[GTP_E_FLAG_BIT];
                pr_pos++;
                if (pr_pos >= GTP_HDR_LEN)
                    move_to(pr_ext_flag ? ST_GTP_NEXT : ST_IN_IP);
            end
            ST_GTP_NEXT:
                move_to((b == 0) ? ST_IN_IP : ST_GTP_LEN);
            ST_GTP_LEN:
            begin
                pr_ext_left = b;
                move_to((b == 0) ? ST_GTP_NEXT : ST_GTP_SKIP);
            end
            ST_GTP_SKIP:
            begin
                pr_ext_left--;
                if (pr_ext_left == 0)
                    move_to(ST_GTP_NEXT);
            end
            ST_IN_IP:
                if (ip_header_done(b, STATUS_BAD_INNER_IP))
                begin
                    if (cfg_proto != PROTO_TCP && cfg_proto != PROTO_UDP)
                        pr_fault = STATUS_UNSUPPORTED;
                    else
                        start_transport();
                end
            ST_TRANS:
                if (pr_pos == TCP_DOFF_OFFSET && cfg_proto == PROTO_TCP &&
                    b[7:4] < TCP_MIN_DOFF)
                    pr_fault = STATUS_BAD_TRANSPORT;
                else
                begin
                    if (pr_pos == TCP_DOFF_OFFSET && cfg_proto == PROTO_TCP)
                        pr_len = {2'b00, b[7:4], 2'b00};
                    pr_pos++;
                    if (pr_pos >= pr_len)
                        move_to(ST_PAYLOAD);
                end
            default: ;
        endcase
    endfunction

    // Advance the walker by one byte and return the result item it gives
    function automatic gdp_result_t next_parse_result(logic [7:0] b, logic last);
        gdp_result_t r;
        r = '0;
        r.payload_byte = b;
        r.packet_done  = last;
        if (pr_fault == STATUS_OK)
        begin
            if (pr_stage == ST_PAYLOAD)
            begin
                r.payload_valid = 1'b1;
                if (pr_count != '1)
                    pr_count++;
                pr_hash = (pr_hash << 5) + pr_hash + b;
            end
            else if (pr_stage == ST_LINK)
            begin
                if (cfg_link > LINK_RAW_IP)
                    pr_fault = STATUS_BAD_LINK;
                else if (cfg_link == LINK_RAW_IP)
                begin
                    move_to(ST_OUT_IP);
                    walk_byte(b);
                end
                else
                begin
                    pr_pos++;
                    if (pr_pos >= ETH_HDR_LEN)
                        move_to(ST_OUT_IP);
                end
            end
            else
                walk_byte(b);
        end
        if (last)
        begin
            if (pr_fault != STATUS_OK)
                r.summary.status = pr_fault;
            else if (pr_stage != ST_PAYLOAD)
            begin
                // Packet ended inside a header: report that header's code
                case (pr_stage)
                    ST_LINK:   r.summary.status = STATUS_BAD_LINK;
                    ST_OUT_IP: r.summary.status = STATUS_BAD_OUTER_IP;
                    ST_OUT_UDP: r.summary.status = STATUS_SHORT_UDP;
                    ST_IN_IP:  r.summary.status = STATUS_BAD_INNER_IP;
                    ST_TRANS:  r.summary.status = STATUS_BAD_TRANSPORT;
                    default:   r.summary.status = STATUS_BAD_GTP;
                endcase
            end
            else if (pr_count == 0)
                r.summary.status = STATUS_EMPTY;
            else
            begin
                r.summary.payload_length = pr_count;
                r.summary.hash_bucket    = pr_hash[BUCKET_BITS-1:0];
            end
            clear_walk();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Frame builder
    // ------------------------------------------------------------------
    function automatic void add_ip_header(logic [7:0] proto);
        logic [3:0] ihl;
        logic [3:0] nib;
        int         words;
        if ($urandom_range(0, 11) == 0)
            ihl = $urandom_range(0, 4);
        else
            ihl = $urandom_range(5, 8);
        words = (ihl < IP_MIN_IHL) ? 5 : ihl;
        nib   = $urandom_range(0, 15);
        frame_q.push_back({nib, ihl});
        for (int i = 1; i < words * 4; i++)
            if (i == IP_PROTO_OFFSET && $urandom_range(0, 7) != 0)
                frame_q.push_back(proto);
            else
                frame_q.push_back($urandom_range(0, 255));
    endfunction

    // Mostly well-formed frames for the current settings, the rest broken
    function automatic void build_frame();
        int         kind;
        int         plen;
        int         elen;
        int         spot;
        logic [7:0] lead;
        logic [3:0] doff;
        logic [3:0] nib;
        frame_q.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 92)
        begin
            repeat ($urandom_range(1, 40))
                frame_q.push_back($urandom_range(0, 255));
            return;
        end
        if (cfg_link == LINK_ETHERNET)
            repeat (ETH_HDR_LEN)
                frame_q.push_back($urandom_range(0, 255));
        add_ip_header(cfg_tunnel ? PROTO_UDP : cfg_proto);
        if (cfg_tunnel)
        begin
            repeat (UDP_HDR_LEN)
                frame_q.push_back($urandom_range(0, 255));
            lead = $urandom_range(0, 255);
            lead[GTP_E_FLAG_BIT] = ($urandom_range(0, 2) != 0);
            frame_q.push_back(lead);
            repeat (GTP_HDR_LEN - 1)
                frame_q.push_back($urandom_range(0, 255));
            if (lead[GTP_E_FLAG_BIT])
            begin
                // Extension chain: type, length, plain bytes; type zero ends it
                repeat ($urandom_range(0, 3))
                begin
                    frame_q.push_back($urandom_range(1, 255));
                    if ($urandom_range(0, 29) == 0)
                        elen = $urandom_range(200, 255);
                    else
                        elen = $urandom_range(0, 6);
                    frame_q.push_back(elen);
                    repeat (elen)
                        frame_q.push_back($urandom_range(0, 255));
                end
                frame_q.push_back(8'd0);
            end
            add_ip_header(cfg_proto);
        end
        if (cfg_proto == PROTO_TCP)
        begin
            if ($urandom_range(0, 15) == 0)
                doff = $urandom_range(0, 4);
            else
                doff = $urandom_range(5, 8);
            for (int i = 0; i < TCP_HDR_LEN; i++)
                if (i == TCP_DOFF_OFFSET)
                begin
                    nib = $urandom_range(0, 15);
                    frame_q.push_back({doff, nib});
                end
                else
                    frame_q.push_back($urandom_range(0, 255));
            for (int i = TCP_HDR_LEN; i < doff * 4; i++)
                frame_q.push_back($urandom_range(0, 255));
        end
        else
            repeat (UDP_HDR_LEN)
                frame_q.push_back($urandom_range(0, 255));
        spot = $urandom_range(0, 99);
        if (spot < 10)
            plen = 0;
        else if (spot < 95)
            plen = $urandom_range(1, 24);
        else
            plen = $urandom_range(100, 300);
        repeat (plen)
            frame_q.push_back($urandom_range(0, 255));
        // Corrupt one byte or cut the frame short
        if (kind >= 80)
        begin
            spot = $urandom_range(0, frame_q.size() - 1);
            frame_q[spot] = $urandom_range(0, 255);
        end
        else if (kind >= 70)
        begin
            spot = $urandom_range(1, frame_q.size());
            while (frame_q.size() > spot)
                void'(frame_q.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one byte, wait for it to be taken, and queue its result item
    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input gdp_result_t want);
        gdp_result_t guess;
        @(negedge clk);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            pkt_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5))
                @(negedge clk);
        end
        pkt_ch.valid       = 1'b1;
        pkt_ch.packet_byte = b;
        pkt_ch.last_byte   = last;
        do
            @(posedge clk);
        while (!pkt_ch.ready);
        guess = next_parse_result(b, last);
        awaited_results.push_back(typed ? want : guess);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
    endtask

    task automatic check_register(input logic [1:0] idx, input logic [31:0] want);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            if (mismatches < MAX_REPORTS)
                $display("register %0d read %h, expected %h", idx, prdata, want);
            mismatches++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Write a register, track it in the walker's copy, and read it back
    task automatic set_register(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_TUNNEL_MODE: cfg_tunnel = val[0];
            REG_LINK_TYPE:   cfg_link   = val[1:0];
            REG_INNER_PROTO: cfg_proto  = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_register(idx, val);
    endtask

    // ------------------------------------------------------------------
    // Clock, stall generator, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drop ready in bursts of random length
    initial
    begin
        int hold;
        hold          = 0;
        res_ch.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                res_ch.ready = 1'b0;
            end
            else if ($urandom_range(0, 99) < snk_idle_pct)
            begin
                hold         = $urandom_range(0, 4);
                res_ch.ready = 1'b0;
            end
            else
                res_ch.ready = 1'b1;
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d result items outstanding", awaited_results.size());
        $display("gtpu_decap_payload_parser test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        gdp_result_t got;
        gdp_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.payload_byte           = res_ch.payload_byte;
            got.payload_valid          = res_ch.payload_valid;
            got.packet_done            = res_ch.packet_done;
            got.summary.status         = gdp_status_t'(res_ch.status);
            got.summary.payload_length = res_ch.payload_length;
            got.summary.hash_bucket    = res_ch.hash_bucket;
            if (got.packet_done === 1'b1)
                status_tally[res_ch.status]++;
            if (awaited_results.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result item: byte %h valid %b done %b status %0d",
                             got.payload_byte, got.payload_valid, got.packet_done,
                             got.summary.status);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got !== want)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display({"mismatch: expected byte %h valid %b done %b status %0d ",
                                  "len %0d bucket %0d, got byte %h valid %b done %b ",
                                  "status %0d len %0d bucket %0d"},
                                 want.payload_byte, want.payload_valid, want.packet_done,
                                 want.summary.status, want.summary.payload_length,
                                 want.summary.hash_bucket, got.payload_byte,
                                 got.payload_valid, got.packet_done, got.summary.status,
                                 got.summary.payload_length, got.summary.hash_bucket);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        gdp_result_t typed_want;
        int          phase_bytes;
        int          packets;
        string       tally_text;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pkt_ch.valid       = 1'b0;
        pkt_ch.packet_byte = '0;
        pkt_ch.last_byte   = 1'b0;
        mismatches         = 0;
        bytes_sent         = 0;
        src_idle_pct       = 0;
        snk_idle_pct       = 0;
        foreach (status_tally[i])
            status_tally[i] = 0;
        cfg_tunnel         = TUNNEL_MODE_RST;
        cfg_link           = LINK_TYPE_RST;
        cfg_proto          = INNER_PROTO_RST;
        clear_walk();
        settings[7].tunnel_mode    = $urandom_range(0, 1);
        settings[7].link_type      = $urandom_range(0, 1) ? LINK_RAW_IP : LINK_ETHERNET;
        settings[7].inner_protocol = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Registers must come out of reset at their documented values
        check_register(REG_TUNNEL_MODE, TUNNEL_MODE_RST);
        check_register(REG_LINK_TYPE, LINK_TYPE_RST);
        check_register(REG_INNER_PROTO, INNER_PROTO_RST);

        // Walk the hand-picked bytes
        src_idle_pct = 12;
        snk_idle_pct = 35;
        foreach (probe_rows[i])
        begin
            typed_want                = '0;
            typed_want.payload_byte   = probe_rows[i].b;
            typed_want.packet_done    = probe_rows[i].last;
            typed_want.summary.status = probe_rows[i].st;
            send_byte(probe_rows[i].b, probe_rows[i].last, probe_rows[i].typed, typed_want);
        end

        for (int ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            // Let the block drain before touching its registers
            if (ph > 0)
            begin
                @(negedge clk);
                pkt_ch.valid = 1'b0;
                while (awaited_results.size() != 0)
                    @(posedge clk);
                set_register(REG_TUNNEL_MODE, settings[ph].tunnel_mode);
                set_register(REG_LINK_TYPE, settings[ph].link_type);
                set_register(REG_INNER_PROTO, settings[ph].inner_protocol);
            end
            if (ph == NUM_SETTINGS - 1)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            else
            begin
                src_idle_pct = (ph % 3 == 0) ? 12 : (ph % 3 == 1) ? 35 : 0;
                snk_idle_pct = (ph % 3 == 0) ? 35 : (ph % 3 == 1) ? 0 : 12;
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                build_frame();
                phase_bytes += frame_q.size();
                send_frame();
            end
        end

        // One raw UDP frame long enough to saturate the payload counter
        frame_q.delete();
        frame_q.push_back(8'h45);
        for (int i = 1; i < 20; i++)
            frame_q.push_back((i == IP_PROTO_OFFSET) ? PROTO_UDP : $urandom_range(0, 255));
        repeat (UDP_HDR_LEN + LONG_PAYLOAD)
            frame_q.push_back($urandom_range(0, 255));
        send_frame();

        // Hold valid low and wait for the last result items
        @(negedge clk);
        pkt_ch.valid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        packets    = 0;
        tally_text = "";
        for (int s = STATUS_OK; s <= STATUS_PROTO_MISMATCH; s++)
        begin
            packets   += status_tally[s];
            tally_text = {tally_text, $sformatf(" %0d", status_tally[s])};
        end
        $display("Summary: %0d bytes, %0d packets across %0d register settings",
                 bytes_sent, packets, NUM_SETTINGS);
        $display("Packets per status code 0..10:%s", tally_text);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("gtpu_decap_payload_parser test passed");
        else
            $display("gtpu_decap_payload_parser test failed");
        $finish;
    end

endmodule
